// ===== rtl/ttu_pkg.sv =====
// ----------------------------------------------------------------------------
// ttu_pkg
// Shared types and constants of the tick stamp to Unix time converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ttu_pkg;

  localparam int unsigned TickHz    = 32768;
  localparam int unsigned FracBits  = $clog2(TickHz);
  localparam int unsigned GcdShift  = 6;
  localparam int unsigned UsecPerS  = 1000000;
  localparam int unsigned UsecMul   = UsecPerS >> GcdShift;
  localparam int unsigned UsecShift = $clog2(TickHz >> GcdShift);
  localparam int unsigned ProdBits  = FracBits + $clog2(UsecMul);

  localparam int unsigned SecW  = 32;
  localparam int unsigned UsecW = 20;
  localparam int unsigned CfgW  = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [UsecW-1:0] UsecPerSec = UsecW'(UsecPerS);
  localparam logic [UsecW-1:0] UsecMax    = UsecW'(UsecPerS - 1);
  localparam logic [SecW-1:0]  LowSecMask = SecW'(32'hF);
  localparam logic [SecW-1:0]  WrapBit    = SecW'(32'h10);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_SEC  = 2'd0,
    CFG_START_USEC = 2'd1,
    CFG_EPOCH_SEC  = 2'd2,
    CFG_EPOCH_USEC = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [SecW-1:0]  start_sec;
    logic [UsecW-1:0] start_usec;
    logic [SecW-1:0]  epoch_sec;
    logic [UsecW-1:0] epoch_usec;
  } cfg_t;

  typedef struct packed {
    logic borrow;
    logic carry;
  } usec_adj_t;

endpackage

// ===== rtl/ttu_cfg.sv =====
// ----------------------------------------------------------------------------
// ttu_cfg
// Configuration registers with saturation of the microsecond fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttu_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ttu_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ttu_pkg::CfgW-1:0]     cfg_data_i,
  output ttu_pkg::cfg_t                cfg_o
);
  import ttu_pkg::*;

  cfg_t             cfg_q;
  logic [UsecW-1:0] usec_clamped;

  assign usec_clamped = (cfg_data_i[UsecW-1:0] > UsecMax) ? UsecMax : cfg_data_i[UsecW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_START_SEC:  cfg_q.start_sec  <= cfg_data_i[SecW-1:0];
        CFG_START_USEC: cfg_q.start_usec <= usec_clamped;
        CFG_EPOCH_SEC:  cfg_q.epoch_sec  <= cfg_data_i[SecW-1:0];
        CFG_EPOCH_USEC: cfg_q.epoch_usec <= usec_clamped;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/ttu_usec.sv =====
// ----------------------------------------------------------------------------
// ttu_usec
// Tick fraction to microseconds, start offset with borrow, epoch with carry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttu_usec (
  input  logic [ttu_pkg::FracBits-1:0] frac_i,
  input  logic [ttu_pkg::UsecW-1:0]    start_usec_i,
  input  logic [ttu_pkg::UsecW-1:0]    epoch_usec_i,
  output logic [ttu_pkg::UsecW-1:0]    usec_o,
  output ttu_pkg::usec_adj_t           adj_o
);
  import ttu_pkg::*;

  logic [ProdBits-1:0] prod;
  logic [UsecW-1:0]    usec_raw;
  logic [UsecW:0]      diff;
  logic [UsecW-1:0]    usec_rel;
  logic [UsecW:0]      sum;

  assign prod     = ProdBits'(frac_i) * ProdBits'(UsecMul);
  assign usec_raw = UsecW'(prod >> UsecShift);

  assign diff        = {1'b0, usec_raw} - {1'b0, start_usec_i};
  assign adj_o.borrow = diff[UsecW];
  assign usec_rel    = adj_o.borrow ? (diff[UsecW-1:0] + UsecPerSec) : diff[UsecW-1:0];

  assign sum         = {1'b0, usec_rel} + {1'b0, epoch_usec_i};
  assign adj_o.carry = (sum >= {1'b0, UsecPerSec});
  assign usec_o      = adj_o.carry ? UsecW'(sum - {1'b0, UsecPerSec}) : sum[UsecW-1:0];

endmodule

// ===== rtl/ttu_secs.sv =====
// ----------------------------------------------------------------------------
// ttu_secs
// Merges coarse and tick seconds, applies start/epoch offsets and carry/borrow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttu_secs (
  input  logic [31:0]                tick_i,
  input  logic [ttu_pkg::SecW-1:0]   coarse_i,
  input  logic [ttu_pkg::SecW-1:0]   start_sec_i,
  input  logic [ttu_pkg::SecW-1:0]   epoch_sec_i,
  input  ttu_pkg::usec_adj_t         adj_i,
  output logic [ttu_pkg::SecW-1:0]   secs_o
);
  import ttu_pkg::*;

  logic [SecW-1:0] tick_secs;
  logic [SecW-1:0] merged;
  logic [SecW-1:0] wrap;
  logic [SecW-1:0] adj;

  assign tick_secs = SecW'(tick_i >> FracBits);
  assign merged    = (coarse_i & ~LowSecMask) | (tick_secs & LowSecMask);
  assign wrap      = (coarse_i & WrapBit) ^ (tick_secs & WrapBit);

  // carry minus borrow, as -1, 0 or +1
  always_comb begin
    case ({adj_i.carry, adj_i.borrow})
      2'b10:   adj = SecW'(1);
      2'b01:   adj = '1;
      default: adj = '0;
    endcase
  end

  assign secs_o = merged - wrap - start_sec_i + epoch_sec_i + adj;

endmodule

// ===== rtl/tick_timestamp_to_unix_time.sv =====
// ----------------------------------------------------------------------------
// tick_timestamp_to_unix_time
// Converts 32768 Hz tick stamps with a coarse seconds count into Unix time.
// ----------------------------------------------------------------------------
// One request per cycle is taken unless the sink stalls: a request register
// feeds the microsecond multiply and the seconds add chain, and a result
// register holds the answer until it is taken. The user must write the four
// configuration registers through the plain write port only while no request
// is in flight (not enforced); microsecond values above 999999 are saturated.
`timescale 1ns / 1ps

module tick_timestamp_to_unix_time (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ttu_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ttu_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [63:0]                 s_axis_tdata,  // tick_stamp, coarse_seconds
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [55:0]                 m_axis_tdata   // unix_seconds, unix_microseconds
);
  import ttu_pkg::*;

  cfg_t             cfg;
  logic             in_vld_q;
  logic [31:0]      tick_q;
  logic [SecW-1:0]  coarse_q;
  logic             out_vld_q;
  logic [SecW-1:0]  secs_q;
  logic [UsecW-1:0] usec_q;
  logic             adv;
  logic [SecW-1:0]  secs_d;
  logic [UsecW-1:0] usec_d;
  usec_adj_t        adj;

  ttu_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      tick_q   <= s_axis_tdata[31:0];
      coarse_q <= s_axis_tdata[63:32];
    end
  end

  ttu_usec u_usec (
    .frac_i       (tick_q[FracBits-1:0]),
    .start_usec_i (cfg.start_usec),
    .epoch_usec_i (cfg.epoch_usec),
    .usec_o       (usec_d),
    .adj_o        (adj)
  );

  ttu_secs u_secs (
    .tick_i      (tick_q),
    .coarse_i    (coarse_q),
    .start_sec_i (cfg.start_sec),
    .epoch_sec_i (cfg.epoch_sec),
    .adj_i       (adj),
    .secs_o      (secs_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_vld_q) begin
      secs_q <= secs_d;
      usec_q <= usec_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'd0, usec_q, secs_q};

`ifndef SYNTHESIS
  a_usec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (usec_q < UsecPerSec))
    else $error("microseconds out of range");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && adv) |=> out_vld_q)
    else $error("request lost between stages");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready) |=> (out_vld_q && $stable(secs_q) && $stable(usec_q)))
    else $error("stalled result changed");
`endif

endmodule
